>>> rtl/core/wts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wts_pkg
// shared constants, codes and control types of the window transfer sender
// ---------------------------------------------------------------------------
package wts_pkg;

  localparam int SEQ_BITS   = 24;
  localparam int MAX_WINDOW = 32;
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);

  localparam int CMD_BITS = 2;
  localparam int ACT_BITS = 3;
  localparam int WIN_BITS = 6;
  localparam int LIM_BITS = 4;
  localparam int IDX_BITS = 2;
  localparam int CFG_BITS = 24;

  // request commands
  localparam logic [CMD_BITS-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_ARRIVE  = 2'd2;

  // result actions
  localparam logic [ACT_BITS-1:0] ACT_HEAD = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_DATA = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_TAIL = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_DONE = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_FAIL = 3'd4;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_FULL_PACKETS = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_WINDOW_SIZE  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MISS_LIMIT   = 2'd2;

  typedef struct packed {
    logic latch;
    logic step;
    logic plan;
    logic emit;
  } wts_cmd_t;

  typedef struct packed {
    logic pending;
    logic out_free;
  } wts_stat_t;

endpackage

>>> rtl/core/wts_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wts_if
// request, result and configuration channels of the window transfer sender
// ---------------------------------------------------------------------------
interface wts_in_if;
  import wts_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  logic                packet_intact;
  logic                ack_flag;
  logic [SEQ_BITS-1:0] ack_number;

  modport source (output valid, cmd, packet_intact, ack_flag, ack_number, input ready);
  modport sink (input valid, cmd, packet_intact, ack_flag, ack_number, output ready);
endinterface

interface wts_out_if;
  import wts_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_BITS-1:0] action;
  logic [SEQ_BITS-1:0] seq_number;
  logic                last;

  modport source (output valid, action, seq_number, last, input ready);
  modport sink (input valid, action, seq_number, last, output ready);
endinterface

interface wts_cfg_if;
  import wts_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/window_transfer_sender.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// window_transfer_sender
// go-back-n style sender sequencer: header, windowed data, tail, done/failed
// ---------------------------------------------------------------------------
// one request at a time: accept, state update, window plan, then one result
// per cycle from the output register while results are taken; a request gives
// 0 to 32 results, each loaded by the emit loop
// synchronous active-high reset: idle phase, base 1, no misses, registers at
// full_packets 0, window_size 8, miss_limit 5; results may be taken while
// the next request is accepted
module window_transfer_sender import wts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wts_in_if.sink    items,
  wts_out_if.source results,
  wts_cfg_if.sink   cfg
);

  wts_cmd_t  ctrl_cmd;
  wts_stat_t dp_stat;

  wts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  wts_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_cmd        (items.cmd),
    .item_intact     (items.packet_intact),
    .item_ack_flag   (items.ack_flag),
    .item_ack_number (items.ack_number),
    .results         (results),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat)
  );

  // a request is only taken once the previous one has no results left
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !dp_stat.pending)
    else $error("request taken while results still pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("request channel open right after a request");

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.emit |-> (dp_stat.pending && dp_stat.out_free))
    else $error("emit without pending result or output space");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.emit |=> results.valid)
    else $error("emitted result not presented");

endmodule

>>> rtl/core/wts_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wts_ctrl
// sequencer: accept a request, update state, plan the window, emit results
// ---------------------------------------------------------------------------
module wts_ctrl import wts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wts_stat_t stat,
  output wts_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_PLAN = 4'b0100,
    S_EMIT = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.pending) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/wts_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wts_datapath
// configuration, transfer state, result plan and output register
// ---------------------------------------------------------------------------
module wts_datapath import wts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  wts_cfg_if.sink             cfg,
  input  logic [CMD_BITS-1:0] item_cmd,
  input  logic                item_intact,
  input  logic                item_ack_flag,
  input  logic [SEQ_BITS-1:0] item_ack_number,
  wts_out_if.source           results,
  input  wts_cmd_t            cmd,
  output wts_stat_t           stat
);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_WIN  = 6'b000100,
    PH_TAIL = 6'b001000,
    PH_DONE = 6'b010000,
    PH_FAIL = 6'b100000
  } phase_t;

  // configuration
  logic [SEQ_BITS-1:0] full_packets;
  logic [WIN_BITS-1:0] window_size;
  logic [LIM_BITS-1:0] miss_limit;

  // transfer state
  phase_t              phase, phase_next;
  logic [SEQ_BITS-1:0] window_base, window_base_next;
  logic [LIM_BITS-1:0] miss_count, miss_count_next;

  // latched request
  logic [CMD_BITS-1:0] l_cmd;
  logic                l_intact;
  logic                l_ack_flag;
  logic [SEQ_BITS-1:0] l_ack;

  // result plan
  logic                pre_pend, pre_pend_next;
  logic [ACT_BITS-1:0] pre_act, pre_act_next;
  logic [SEQ_BITS-1:0] pre_seq, pre_seq_next;
  logic                want_win, want_win_next;
  logic                fail_pend, fail_pend_next;
  logic [CNT_BITS-1:0] data_left;
  logic [SEQ_BITS-1:0] data_seq;

  // output register
  logic                out_valid;
  logic [ACT_BITS-1:0] out_action;
  logic [SEQ_BITS-1:0] out_seq;
  logic                out_last;

  logic [SEQ_BITS:0]   end_seq;
  logic [SEQ_BITS:0]   base_ext;
  logic [LIM_BITS:0]   miss_inc;
  logic [LIM_BITS-1:0] lim_eff;
  logic                miss_hit;
  logic                ack_in_range;
  logic [SEQ_BITS-1:0] base_adv;
  logic [CNT_BITS-1:0] win_eff;
  logic [SEQ_BITS:0]   span;
  logic [CNT_BITS-1:0] win_count;
  logic [CNT_BITS:0]   remaining;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_packets <= '0;
      window_size  <= WIN_BITS'(8);
      miss_limit   <= LIM_BITS'(5);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FULL_PACKETS: full_packets <= cfg.data[SEQ_BITS-1:0];
        REG_WINDOW_SIZE:  window_size  <= cfg.data[WIN_BITS-1:0];
        REG_MISS_LIMIT:   miss_limit   <= cfg.data[LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign end_seq  = {1'b0, full_packets} + (SEQ_BITS+1)'(1);
  assign base_ext = {1'b0, window_base};
  assign miss_inc = {1'b0, miss_count} + (LIM_BITS+1)'(1);
  assign lim_eff  = (miss_limit == '0) ? LIM_BITS'(1) : miss_limit;
  assign miss_hit = miss_inc >= {1'b0, lim_eff};
  assign ack_in_range = l_intact && l_ack_flag && (l_ack >= window_base)
                        && ({1'b0, l_ack} <= end_seq);
  assign base_adv = ack_in_range ? l_ack : window_base;

  // state update for the latched request
  always_comb begin
    phase_next       = phase;
    window_base_next = window_base;
    miss_count_next  = miss_count;
    pre_pend_next    = 1'b0;
    pre_act_next     = ACT_HEAD;
    pre_seq_next     = '0;
    want_win_next    = 1'b0;
    fail_pend_next   = 1'b0;
    unique case (l_cmd)
      CMD_START: begin
        window_base_next = SEQ_BITS'(1);
        miss_count_next  = '0;
        phase_next       = PH_HEAD;
        pre_pend_next    = 1'b1;
      end
      CMD_TIMEOUT: begin
        if (phase == PH_HEAD || phase == PH_TAIL) begin
          pre_pend_next   = 1'b1;
          pre_act_next    = (phase == PH_HEAD) ? ACT_HEAD : ACT_TAIL;
          pre_seq_next    = (phase == PH_HEAD) ? '0 : window_base;
          miss_count_next = miss_inc[LIM_BITS-1:0];
          if (miss_hit) begin
            phase_next     = PH_FAIL;
            fail_pend_next = 1'b1;
          end
        end else if (phase == PH_WIN) begin
          miss_count_next = miss_inc[LIM_BITS-1:0];
          if (miss_hit) begin
            phase_next     = PH_FAIL;
            fail_pend_next = 1'b1;
          end else begin
            want_win_next = 1'b1;
          end
        end
      end
      CMD_ARRIVE: begin
        if (phase == PH_HEAD) begin
          if (!l_intact) begin
            pre_pend_next = 1'b1;
          end else if (l_ack_flag && l_ack == '0) begin
            window_base_next = SEQ_BITS'(1);
            miss_count_next  = '0;
            if (full_packets == '0) begin
              phase_next    = PH_TAIL;
              pre_pend_next = 1'b1;
              pre_act_next  = ACT_TAIL;
              pre_seq_next  = SEQ_BITS'(1);
            end else begin
              phase_next    = PH_WIN;
              want_win_next = 1'b1;
            end
          end else if (l_ack_flag) begin
            pre_pend_next = 1'b1;
          end
        end else if (phase == PH_TAIL) begin
          if (!l_intact) begin
            pre_pend_next = 1'b1;
            pre_act_next  = ACT_TAIL;
            pre_seq_next  = window_base;
          end else if (l_ack_flag && l_ack == window_base + SEQ_BITS'(1)) begin
            phase_next    = PH_DONE;
            pre_pend_next = 1'b1;
            pre_act_next  = ACT_DONE;
          end else if (l_ack_flag) begin
            pre_pend_next = 1'b1;
            pre_act_next  = ACT_TAIL;
            pre_seq_next  = window_base;
          end
        end else if (phase == PH_WIN) begin
          miss_count_next  = '0;
          window_base_next = base_adv;
          if ({1'b0, base_adv} == end_seq) begin
            phase_next    = PH_TAIL;
            pre_pend_next = 1'b1;
            pre_act_next  = ACT_TAIL;
            pre_seq_next  = base_adv;
          end else begin
            want_win_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // packets in the window (size clamped to 1..MAX_WINDOW), cut at the end of the file
  always_comb begin
    priority if (window_size == '0) begin
      win_eff = CNT_BITS'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      win_eff = CNT_BITS'(MAX_WINDOW);
    end else begin
      win_eff = CNT_BITS'(window_size);
    end
  end

  assign span = end_seq - base_ext;

  always_comb begin
    priority if (end_seq <= base_ext) begin
      win_count = '0;
    end else if (span > (SEQ_BITS+1)'(win_eff)) begin
      win_count = win_eff;
    end else begin
      win_count = span[CNT_BITS-1:0];
    end
  end

  assign remaining = (CNT_BITS+1)'(pre_pend) + (CNT_BITS+1)'(data_left)
                     + (CNT_BITS+1)'(fail_pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      window_base <= SEQ_BITS'(1);
      miss_count  <= '0;
      pre_pend    <= 1'b0;
      fail_pend   <= 1'b0;
      data_left   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.step) begin
        phase       <= phase_next;
        window_base <= window_base_next;
        miss_count  <= miss_count_next;
        pre_pend    <= pre_pend_next;
        fail_pend   <= fail_pend_next;
      end
      if (cmd.plan) begin
        data_left <= want_win ? win_count : '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        priority if (pre_pend) begin
          pre_pend <= 1'b0;
        end else if (data_left != '0) begin
          data_left <= data_left - CNT_BITS'(1);
        end else begin
          fail_pend <= 1'b0;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_cmd      <= item_cmd;
      l_intact   <= item_intact;
      l_ack_flag <= item_ack_flag;
      l_ack      <= item_ack_number;
    end
    if (cmd.step) begin
      pre_act  <= pre_act_next;
      pre_seq  <= pre_seq_next;
      want_win <= want_win_next;
    end
    if (cmd.plan) begin
      data_seq <= window_base;
    end
    if (cmd.emit) begin
      out_last <= (remaining == (CNT_BITS+1)'(1));
      priority if (pre_pend) begin
        out_action <= pre_act;
        out_seq    <= pre_seq;
      end else if (data_left != '0) begin
        out_action <= ACT_DATA;
        out_seq    <= data_seq;
        data_seq   <= data_seq + SEQ_BITS'(1);
      end else begin
        out_action <= ACT_FAIL;
        out_seq    <= '0;
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.action     = out_action;
  assign results.seq_number = out_seq;
  assign results.last       = out_last;

  assign stat.pending  = pre_pend || fail_pend || (data_left != '0);
  assign stat.out_free = !out_valid || results.ready;

endmodule
